// File: hw/rtl/kfpv_pkg.sv
// package: shared types, constants and the micro-program of the filter sequencer
package kfpv_pkg;

	localparam int W = 48;
	localparam int CW = 47;
	localparam int RAM_DEPTH = 32;
	localparam int RA = $clog2(RAM_DEPTH);
	localparam int PCW = 7;
	localparam int NOUT = 10;

	localparam logic [W-1:0] COV_INIT = 48'd429496730;
	localparam logic [CW-1:0] DT_RST = 47'd4294967;
	localparam logic [CW-1:0] QP_RST = 47'd42950;
	localparam logic [CW-1:0] QV_RST = 47'd4294967;
	localparam logic [CW-1:0] RP_RST = 47'd4295;
	localparam logic [CW-1:0] RV_RST = 47'd42949673;

	// register indexes of the config port
	localparam logic [2:0] CFG_DT = 3'd0;
	localparam logic [2:0] CFG_QP = 3'd1;
	localparam logic [2:0] CFG_QV = 3'd2;
	localparam logic [2:0] CFG_RP = 3'd3;
	localparam logic [2:0] CFG_RV = 3'd4;

	// item kinds
	localparam logic [1:0] K_INIT = 2'd0;
	localparam logic [1:0] K_PRED = 2'd1;
	localparam logic [1:0] K_UPD = 2'd2;

	// micro-ops
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_JMP = 3'd4;
	localparam logic [2:0] OP_BRZ = 3'd5;
	localparam logic [2:0] OP_DONE = 3'd6;
	localparam logic [2:0] OP_HALT = 3'd7;

	// scratch ram addresses
	localparam logic [5:0] R_EP = 6'd0;
	localparam logic [5:0] R_EV = 6'd1;
	localparam logic [5:0] R_C0 = 6'd2;
	localparam logic [5:0] R_C1 = 6'd3;
	localparam logic [5:0] R_C2 = 6'd4;
	localparam logic [5:0] R_C3 = 6'd5;
	localparam logic [5:0] R_S00 = 6'd6;
	localparam logic [5:0] R_S11 = 6'd7;
	localparam logic [5:0] R_DET = 6'd8;
	localparam logic [5:0] R_I00 = 6'd9;
	localparam logic [5:0] R_I01 = 6'd10;
	localparam logic [5:0] R_I10 = 6'd11;
	localparam logic [5:0] R_I11 = 6'd12;
	localparam logic [5:0] R_K0 = 6'd13;
	localparam logic [5:0] R_K1 = 6'd14;
	localparam logic [5:0] R_K2 = 6'd15;
	localparam logic [5:0] R_K3 = 6'd16;
	localparam logic [5:0] R_Y0 = 6'd17;
	localparam logic [5:0] R_Y1 = 6'd18;
	localparam logic [5:0] R_N0 = 6'd19;
	localparam logic [5:0] R_N1 = 6'd20;
	localparam logic [5:0] R_N2 = 6'd21;
	localparam logic [5:0] R_N3 = 6'd22;
	localparam logic [5:0] R_A00 = 6'd23;
	localparam logic [5:0] R_A01 = 6'd24;
	localparam logic [5:0] R_T0 = 6'd25;
	localparam logic [5:0] R_T1 = 6'd26;

	// operand sources outside the ram
	localparam logic [5:0] S_Z = 6'd32;
	localparam logic [5:0] S_DT = 6'd33;
	localparam logic [5:0] S_QP = 6'd34;
	localparam logic [5:0] S_QV = 6'd35;
	localparam logic [5:0] S_RP = 6'd36;
	localparam logic [5:0] S_RV = 6'd37;
	localparam logic [5:0] S_C01 = 6'd38;
	localparam logic [5:0] S_ZP = 6'd39;
	localparam logic [5:0] S_ZV = 6'd40;

	// result slots
	localparam logic [3:0] O_POS = 4'd0;
	localparam logic [3:0] O_VEL = 4'd1;
	localparam logic [3:0] O_C0 = 4'd2;
	localparam logic [3:0] O_C1 = 4'd3;
	localparam logic [3:0] O_C2 = 4'd4;
	localparam logic [3:0] O_C3 = 4'd5;
	localparam logic [3:0] O_K0 = 4'd6;
	localparam logic [3:0] O_K1 = 4'd7;
	localparam logic [3:0] O_K2 = 4'd8;
	localparam logic [3:0] O_K3 = 4'd9;
	localparam logic [3:0] O_NONE = 4'd15;

	// program entry points
	localparam logic [PCW-1:0] P_INIT = 7'd0;
	localparam logic [PCW-1:0] P_LOAD = 7'd7;
	localparam logic [PCW-1:0] P_PRED = 7'd10;
	localparam logic [PCW-1:0] P_UPD = 7'd24;
	localparam logic [PCW-1:0] P_UBODY = 7'd48;
	localparam logic [PCW-1:0] P_FIN = 7'd79;
	localparam logic [PCW-1:0] P_ZK = 7'd104;
	localparam logic [PCW-1:0] P_OUTS = 7'd108;

	typedef struct packed {
		logic [2:0] op;
		logic [RA-1:0] dst;
		logic wr;
		logic [3:0] os;
		logic [5:0] sa;
		logic [5:0] sb;
		logic mark;
		logic [PCW-1:0] tgt;
	} uop_t;

	typedef struct packed {
		logic take;
		logic go;
		logic publish;
		logic sing;
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic zero;
		logic out_free;
	} sts_t;

	function automatic uop_t u_alu(input logic [2:0] op, input logic [5:0] dst,
			input logic wr, input logic [3:0] os, input logic [5:0] sa, input logic [5:0] sb);
		uop_t u;
		u.op = op;
		u.dst = dst[RA-1:0];
		u.wr = wr;
		u.os = os;
		u.sa = sa;
		u.sb = sb;
		u.mark = 1'b0;
		u.tgt = '0;
		return u;
	endfunction

	function automatic uop_t u_br(input logic [2:0] op, input logic mark,
			input logic [PCW-1:0] tgt);
		uop_t u;
		u = u_alu(op, R_EP, 1'b0, O_NONE, S_Z, S_Z);
		u.mark = mark;
		u.tgt = tgt;
		return u;
	endfunction

	// gain of the current covariance, K = P (P + R)^-1
	function automatic uop_t gain_op(input logic [4:0] off, input logic fin);
		uop_t u;
		u = u_br(OP_HALT, 1'b0, P_INIT);
		case (off)
			5'd0: u = u_alu(OP_ADD, R_S00, 1'b1, O_NONE, R_C0, S_RP);
			5'd1: u = u_alu(OP_ADD, R_S11, 1'b1, O_NONE, R_C3, S_RV);
			5'd2: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_S00, R_S11);
			5'd3: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_C1, R_C2);
			5'd4: u = u_alu(OP_SUB, R_DET, 1'b1, O_NONE, R_T0, R_T1);
			5'd5: u = fin ? u_br(OP_BRZ, 1'b0, P_ZK) : u_br(OP_BRZ, 1'b1, P_FIN);
			5'd6: u = u_alu(OP_DIV, R_I00, 1'b1, O_NONE, R_S11, R_DET);
			5'd7: u = u_alu(OP_SUB, R_T0, 1'b1, O_NONE, S_Z, R_C1);
			5'd8: u = u_alu(OP_DIV, R_I01, 1'b1, O_NONE, R_T0, R_DET);
			5'd9: u = u_alu(OP_SUB, R_T0, 1'b1, O_NONE, S_Z, R_C2);
			5'd10: u = u_alu(OP_DIV, R_I10, 1'b1, O_NONE, R_T0, R_DET);
			5'd11: u = u_alu(OP_DIV, R_I11, 1'b1, O_NONE, R_S00, R_DET);
			5'd12: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_C0, R_I00);
			5'd13: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_C1, R_I10);
			5'd14: u = u_alu(OP_ADD, R_K0, 1'b1, fin ? O_K0 : O_NONE, R_T0, R_T1);
			5'd15: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_C0, R_I01);
			5'd16: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_C1, R_I11);
			5'd17: u = u_alu(OP_ADD, R_K1, 1'b1, fin ? O_K1 : O_NONE, R_T0, R_T1);
			5'd18: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_C2, R_I00);
			5'd19: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_C3, R_I10);
			5'd20: u = u_alu(OP_ADD, R_K2, 1'b1, fin ? O_K2 : O_NONE, R_T0, R_T1);
			5'd21: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_C2, R_I01);
			5'd22: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_C3, R_I11);
			5'd23: u = u_alu(OP_ADD, R_K3, 1'b1, fin ? O_K3 : O_NONE, R_T0, R_T1);
			default: u = u_br(OP_HALT, 1'b0, P_INIT);
		endcase
		return u;
	endfunction

	function automatic uop_t prog(input logic [PCW-1:0] pc);
		uop_t u;
		logic [PCW-1:0] rel_u;
		logic [PCW-1:0] rel_f;
		rel_u = pc - P_UPD;
		rel_f = pc - P_FIN;
		u = u_br(OP_HALT, 1'b0, P_INIT);
		if (pc >= P_UPD && pc < P_UBODY) begin
			u = gain_op(rel_u[4:0], 1'b0);
		end else if (pc >= P_FIN && pc < P_FIN + 7'd24) begin
			u = gain_op(rel_f[4:0], 1'b1);
		end else begin
			case (pc)
				7'd0: u = u_alu(OP_ADD, R_EP, 1'b1, O_NONE, S_Z, S_Z);
				7'd1: u = u_alu(OP_ADD, R_EV, 1'b1, O_NONE, S_Z, S_Z);
				7'd2: u = u_alu(OP_ADD, R_C0, 1'b1, O_NONE, S_C01, S_Z);
				7'd3: u = u_alu(OP_ADD, R_C1, 1'b1, O_NONE, S_Z, S_Z);
				7'd4: u = u_alu(OP_ADD, R_C2, 1'b1, O_NONE, S_Z, S_Z);
				7'd5: u = u_alu(OP_ADD, R_C3, 1'b1, O_NONE, S_C01, S_Z);
				7'd6: u = u_br(OP_HALT, 1'b0, P_INIT);
				7'd7: u = u_alu(OP_ADD, R_EP, 1'b1, O_NONE, S_ZP, S_Z);
				7'd8: u = u_alu(OP_ADD, R_EV, 1'b1, O_NONE, S_ZV, S_Z);
				7'd9: u = u_br(OP_JMP, 1'b0, P_FIN);
				7'd10: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, S_DT, R_C2);
				7'd11: u = u_alu(OP_ADD, R_A00, 1'b1, O_NONE, R_C0, R_T0);
				7'd12: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, S_DT, R_C3);
				7'd13: u = u_alu(OP_ADD, R_A01, 1'b1, O_NONE, R_C1, R_T0);
				7'd14: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, S_DT, R_EV);
				7'd15: u = u_alu(OP_ADD, R_EP, 1'b1, O_NONE, R_EP, R_T0);
				7'd16: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, S_DT, R_A01);
				7'd17: u = u_alu(OP_ADD, R_T1, 1'b1, O_NONE, R_A00, R_T0);
				7'd18: u = u_alu(OP_ADD, R_C0, 1'b1, O_NONE, R_T1, S_QP);
				7'd19: u = u_alu(OP_ADD, R_C1, 1'b1, O_NONE, R_A01, S_Z);
				7'd20: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, S_DT, R_C3);
				7'd21: u = u_alu(OP_ADD, R_C2, 1'b1, O_NONE, R_C2, R_T0);
				7'd22: u = u_alu(OP_ADD, R_C3, 1'b1, O_NONE, R_C3, S_QV);
				7'd23: u = u_br(OP_JMP, 1'b0, P_FIN);
				7'd48: u = u_alu(OP_SUB, R_Y0, 1'b1, O_NONE, S_ZP, R_EP);
				7'd49: u = u_alu(OP_SUB, R_Y1, 1'b1, O_NONE, S_ZV, R_EV);
				7'd50: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_K0, R_Y0);
				7'd51: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_K1, R_Y1);
				7'd52: u = u_alu(OP_ADD, R_T0, 1'b1, O_NONE, R_T0, R_T1);
				7'd53: u = u_alu(OP_ADD, R_EP, 1'b1, O_NONE, R_EP, R_T0);
				7'd54: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_K2, R_Y0);
				7'd55: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_K3, R_Y1);
				7'd56: u = u_alu(OP_ADD, R_T0, 1'b1, O_NONE, R_T0, R_T1);
				7'd57: u = u_alu(OP_ADD, R_EV, 1'b1, O_NONE, R_EV, R_T0);
				7'd58: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_K0, R_C0);
				7'd59: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_K1, R_C2);
				7'd60: u = u_alu(OP_ADD, R_T0, 1'b1, O_NONE, R_T0, R_T1);
				7'd61: u = u_alu(OP_SUB, R_N0, 1'b1, O_NONE, R_C0, R_T0);
				7'd62: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_K0, R_C1);
				7'd63: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_K1, R_C3);
				7'd64: u = u_alu(OP_ADD, R_T0, 1'b1, O_NONE, R_T0, R_T1);
				7'd65: u = u_alu(OP_SUB, R_N1, 1'b1, O_NONE, R_C1, R_T0);
				7'd66: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_K2, R_C0);
				7'd67: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_K3, R_C2);
				7'd68: u = u_alu(OP_ADD, R_T0, 1'b1, O_NONE, R_T0, R_T1);
				7'd69: u = u_alu(OP_SUB, R_N2, 1'b1, O_NONE, R_C2, R_T0);
				7'd70: u = u_alu(OP_MUL, R_T0, 1'b1, O_NONE, R_K2, R_C1);
				7'd71: u = u_alu(OP_MUL, R_T1, 1'b1, O_NONE, R_K3, R_C3);
				7'd72: u = u_alu(OP_ADD, R_T0, 1'b1, O_NONE, R_T0, R_T1);
				7'd73: u = u_alu(OP_SUB, R_N3, 1'b1, O_NONE, R_C3, R_T0);
				7'd74: u = u_alu(OP_ADD, R_C0, 1'b1, O_NONE, R_N0, S_Z);
				7'd75: u = u_alu(OP_ADD, R_C1, 1'b1, O_NONE, R_N1, S_Z);
				7'd76: u = u_alu(OP_ADD, R_C2, 1'b1, O_NONE, R_N2, S_Z);
				7'd77: u = u_alu(OP_ADD, R_C3, 1'b1, O_NONE, R_N3, S_Z);
				7'd78: u = u_br(OP_JMP, 1'b0, P_FIN);
				7'd103: u = u_br(OP_JMP, 1'b0, P_OUTS);
				7'd104: u = u_alu(OP_ADD, R_EP, 1'b0, O_K0, S_Z, S_Z);
				7'd105: u = u_alu(OP_ADD, R_EP, 1'b0, O_K1, S_Z, S_Z);
				7'd106: u = u_alu(OP_ADD, R_EP, 1'b0, O_K2, S_Z, S_Z);
				7'd107: u = u_alu(OP_ADD, R_EP, 1'b0, O_K3, S_Z, S_Z);
				7'd108: u = u_alu(OP_ADD, R_EP, 1'b0, O_POS, R_EP, S_Z);
				7'd109: u = u_alu(OP_ADD, R_EP, 1'b0, O_VEL, R_EV, S_Z);
				7'd110: u = u_alu(OP_ADD, R_EP, 1'b0, O_C0, R_C0, S_Z);
				7'd111: u = u_alu(OP_ADD, R_EP, 1'b0, O_C1, R_C1, S_Z);
				7'd112: u = u_alu(OP_ADD, R_EP, 1'b0, O_C2, R_C2, S_Z);
				7'd113: u = u_alu(OP_ADD, R_EP, 1'b0, O_C3, R_C3, S_Z);
				7'd114: u = u_br(OP_DONE, 1'b0, P_INIT);
				default: u = u_br(OP_HALT, 1'b0, P_INIT);
			endcase
		end
		return u;
	endfunction

endpackage

// File: hw/rtl/kfpv_ram.sv
// generic single-write, single-read ram with registered read data
module kfpv_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/kfpv_dp.sv
// datapath: config registers, scratch rams, saturating add, serial multiply and divide, result register
module kfpv_dp (
	input logic clk,
	input logic arst_n,
	input kfpv_pkg::cmd_t cmd,
	output kfpv_pkg::sts_t st,
	input logic [kfpv_pkg::W-1:0] pos_value,
	input logic [kfpv_pkg::W-1:0] vel_value,
	input logic cfg_wr_en,
	input logic [2:0] cfg_index,
	input logic [kfpv_pkg::CW-1:0] cfg_data,
	input logic m_tready,
	output logic m_tvalid,
	output logic [kfpv_pkg::NOUT*kfpv_pkg::W-1:0] m_tdata,
	output logic [0:0] m_tuser
);

	localparam int W = kfpv_pkg::W;
	localparam int RA = kfpv_pkg::RA;

	logic [kfpv_pkg::CW-1:0] dt_q, qp_q, qv_q, rp_q, rv_q;
	logic [W-1:0] zp_q, zv_q;
	logic [W-1:0] ra_data, rb_data;
	logic [W-1:0] opa, opb;
	logic [W-1:0] a_q, b_q, ma_q, mb_q;
	logic neg_q;
	logic [2:0] op_q;
	logic [RA-1:0] dst_q;
	logic wr_q;
	logic [3:0] os_q;
	logic busy_q;
	logic [6:0] cnt_q;
	logic [63:0] p_q, acc_q;
	logic [31:0] mx, my;
	logic [63:0] prod;
	logic [W-1:0] r_q;
	logic [50:0] q_q;
	logic big_q;
	logic [W-1:0] dv_q;
	logic [W:0] r2;
	logic big_n, ge;
	logic [50:0] q_sh, q_n;
	logic [W:0] r_n;
	logic [51:0] qf;
	logic [W:0] sum;
	logic [W-1:0] res;
	logic done;
	logic zero_q;
	logic [W-1:0] stage_q [kfpv_pkg::NOUT];
	logic m_tvalid_q;
	logic [kfpv_pkg::NOUT*W-1:0] m_tdata_q;
	logic m_tuser_q;

	function automatic logic [W-1:0] mag(input logic [W-1:0] a);
		return a[W-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic [W-1:0] signsat(input logic [63:0] m, input logic neg);
		logic [W-1:0] r;
		if (neg) begin
			r = (m >= 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000 : (~m[W-1:0] + 1'b1);
		end else begin
			r = (m > 64'h0000_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : m[W-1:0];
		end
		return r;
	endfunction

	function automatic logic [W-1:0] src_val(input logic [5:0] s, input logic [W-1:0] rd,
			input logic [kfpv_pkg::CW-1:0] dt, input logic [kfpv_pkg::CW-1:0] qp,
			input logic [kfpv_pkg::CW-1:0] qv, input logic [kfpv_pkg::CW-1:0] rp,
			input logic [kfpv_pkg::CW-1:0] rv, input logic [W-1:0] zp, input logic [W-1:0] zv);
		logic [W-1:0] v;
		v = '0;
		if (!s[5]) begin
			v = rd;
		end else begin
			case (s)
				kfpv_pkg::S_DT: v = {1'b0, dt};
				kfpv_pkg::S_QP: v = {1'b0, qp};
				kfpv_pkg::S_QV: v = {1'b0, qv};
				kfpv_pkg::S_RP: v = {1'b0, rp};
				kfpv_pkg::S_RV: v = {1'b0, rv};
				kfpv_pkg::S_C01: v = kfpv_pkg::COV_INIT;
				kfpv_pkg::S_ZP: v = zp;
				kfpv_pkg::S_ZV: v = zv;
				default: v = '0;
			endcase
		end
		return v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= kfpv_pkg::DT_RST;
			qp_q <= kfpv_pkg::QP_RST;
			qv_q <= kfpv_pkg::QV_RST;
			rp_q <= kfpv_pkg::RP_RST;
			rv_q <= kfpv_pkg::RV_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				kfpv_pkg::CFG_DT: dt_q <= cfg_data;
				kfpv_pkg::CFG_QP: qp_q <= cfg_data;
				kfpv_pkg::CFG_QV: qv_q <= cfg_data;
				kfpv_pkg::CFG_RP: rp_q <= cfg_data;
				kfpv_pkg::CFG_RV: rv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			zp_q <= pos_value;
			zv_q <= vel_value;
		end
	end

	kfpv_ram #(.WIDTH(W), .DEPTH(kfpv_pkg::RAM_DEPTH)) u_ram_a (
		.clk(clk),
		.we(done && wr_q),
		.waddr(dst_q),
		.wdata(res),
		.raddr(cmd.uop.sa[RA-1:0]),
		.rdata(ra_data)
	);

	kfpv_ram #(.WIDTH(W), .DEPTH(kfpv_pkg::RAM_DEPTH)) u_ram_b (
		.clk(clk),
		.we(done && wr_q),
		.waddr(dst_q),
		.wdata(res),
		.raddr(cmd.uop.sb[RA-1:0]),
		.rdata(rb_data)
	);

	assign opa = src_val(cmd.uop.sa, ra_data, dt_q, qp_q, qv_q, rp_q, rv_q, zp_q, zv_q);
	assign opb = src_val(cmd.uop.sb, rb_data, dt_q, qp_q, qv_q, rp_q, rv_q, zp_q, zv_q);

	// partial products of the magnitudes, low halves first
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				mx = ma_q[31:0];
				my = mb_q[31:0];
			end
			2'd1: begin
				mx = ma_q[31:0];
				my = {16'd0, mb_q[W-1:32]};
			end
			2'd2: begin
				mx = {16'd0, ma_q[W-1:32]};
				my = mb_q[31:0];
			end
			default: begin
				mx = {16'd0, ma_q[W-1:32]};
				my = {16'd0, mb_q[W-1:32]};
			end
		endcase
	end
	assign prod = mx * my;

	// one restoring divide step
	always_comb begin
		r2 = {r_q, dv_q[W-1]};
		big_n = big_q || (q_q >= 51'h4_0000_0000_0000);
		q_sh = big_n ? q_q : {q_q[49:0], 1'b0};
		ge = r2 >= {1'b0, mb_q};
		r_n = ge ? (r2 - {1'b0, mb_q}) : r2;
		q_n = (ge && !big_n) ? (q_sh | 51'd1) : q_sh;
		qf = big_q ? 52'h4_0000_0000_0000 :
			({1'b0, q_q} + {51'd0, ({r_q, 1'b0} >= {1'b0, mb_q})});
	end

	always_comb begin
		sum = (op_q == kfpv_pkg::OP_SUB) ? ({a_q[W-1], a_q} - {b_q[W-1], b_q}) :
			({a_q[W-1], a_q} + {b_q[W-1], b_q});
		res = '0;
		done = 1'b0;
		if (busy_q) begin
			case (op_q)
				kfpv_pkg::OP_MUL: begin
					done = (cnt_q == 7'd5);
					res = signsat(acc_q, neg_q);
				end
				kfpv_pkg::OP_DIV: begin
					done = (cnt_q == 7'd80);
					res = signsat({12'd0, qf}, neg_q);
				end
				default: begin
					done = 1'b1;
					if (sum[W] != sum[W-1]) begin
						res = sum[W] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
					end else begin
						res = sum[W-1:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.go) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			cnt_q <= cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			op_q <= cmd.uop.op;
			dst_q <= cmd.uop.dst;
			wr_q <= cmd.uop.wr;
			os_q <= cmd.uop.os;
			a_q <= opa;
			b_q <= opb;
			ma_q <= mag(opa);
			mb_q <= mag(opb);
			neg_q <= opa[W-1] ^ opb[W-1];
			r_q <= '0;
			q_q <= '0;
			big_q <= 1'b0;
			dv_q <= mag(opa);
		end else if (busy_q) begin
			if (op_q == kfpv_pkg::OP_MUL) begin
				p_q <= prod;
				case (cnt_q)
					7'd1: acc_q <= {32'd0, p_q[63:32]} + {63'd0, (p_q[31:0] >= 32'h8000_0000)};
					7'd2: acc_q <= acc_q + p_q;
					7'd3: acc_q <= acc_q + p_q;
					7'd4: acc_q <= acc_q + {p_q[31:0], 32'd0};
					default: ;
				endcase
			end else if (op_q == kfpv_pkg::OP_DIV && cnt_q < 7'd80) begin
				r_q <= r_n[W-1:0];
				q_q <= q_n;
				big_q <= big_n;
				dv_q <= {dv_q[W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b0;
		end else if (done) begin
			zero_q <= (res == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (done && os_q != kfpv_pkg::O_NONE) begin
			stage_q[os_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.publish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			for (int i = 0; i < kfpv_pkg::NOUT; i++) begin
				m_tdata_q[i*W +: W] <= stage_q[i];
			end
			m_tuser_q <= cmd.sing;
		end
	end

	assign st.done = done;
	assign st.zero = zero_q;
	assign st.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

// File: hw/rtl/kfpv_ctrl.sv
// controller: micro-program sequencer that steps the datapath through each filter step
module kfpv_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [1:0] kind,
	input kfpv_pkg::sts_t st,
	output kfpv_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_PUB = 3'd4;

	logic [2:0] state_q;
	logic [kfpv_pkg::PCW-1:0] pc_q;
	logic sing_q;
	kfpv_pkg::uop_t uop;
	logic take;

	assign uop = kfpv_pkg::prog(pc_q);
	assign s_tready = (state_q == ST_IDLE);
	assign take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FETCH;
			pc_q <= kfpv_pkg::P_INIT;
			sing_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						sing_q <= 1'b0;
						state_q <= ST_FETCH;
						unique case (kind)
							kfpv_pkg::K_INIT: pc_q <= kfpv_pkg::P_LOAD;
							kfpv_pkg::K_PRED: pc_q <= kfpv_pkg::P_PRED;
							kfpv_pkg::K_UPD: pc_q <= kfpv_pkg::P_UPD;
							default: pc_q <= kfpv_pkg::P_FIN;
						endcase
					end
				end
				ST_FETCH: begin
					unique case (uop.op)
						kfpv_pkg::OP_JMP: pc_q <= uop.tgt;
						kfpv_pkg::OP_BRZ: begin
							if (st.zero) begin
								pc_q <= uop.tgt;
								if (uop.mark) begin
									sing_q <= 1'b1;
								end
							end else begin
								pc_q <= pc_q + 1'b1;
							end
						end
						kfpv_pkg::OP_DONE: state_q <= ST_PUB;
						kfpv_pkg::OP_HALT: state_q <= ST_IDLE;
						default: state_q <= ST_EXEC;
					endcase
				end
				ST_EXEC: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (st.done) begin
						pc_q <= pc_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_PUB: begin
					if (st.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.take = take;
		cmd.go = (state_q == ST_EXEC);
		cmd.publish = (state_q == ST_PUB) && st.out_free;
		cmd.sing = sing_q;
		cmd.uop = uop;
	end

endmodule

// File: hw/rtl/kalman_filter_pos_vel.sv
// top level: two-state constant-velocity kalman filter with stream ports
// Position/velocity Kalman filter in signed Q16.32. Each input item selects
// initialize, predict or update in s_tuser (kind 3 leaves the state as it is)
// and returns one result item with the state, the covariance, the gain
// implied by the new covariance and a singular flag. Steps run one at a time
// through a micro-programmed sequencer over a saturating adder, a multiplier
// built on one 32x32 unit and a restoring divider (80 steps a quotient).
// An update evaluates the gain twice, with four divides each time the
// determinant is nonzero. After reset a pass of the micro-program loads the
// initial state before s_tready rises.
// A finished result waits in the output register while the next item runs.
module kalman_filter_pos_vel (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [95:0] s_tdata, // pos_value, vel_value
	input logic [1:0] s_tuser, // kind
	output logic m_tvalid,
	input logic m_tready,
	// position, velocity, cov_pp, cov_pv, cov_vp, cov_vv, gain_pp, gain_pv, gain_vp, gain_vv
	output logic [479:0] m_tdata,
	output logic [0:0] m_tuser, // singular
	input logic cfg_wr_en,
	input logic [2:0] cfg_index,
	input logic [46:0] cfg_data
);

	kfpv_pkg::cmd_t cmd;
	kfpv_pkg::sts_t st;

	kfpv_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.kind(s_tuser),
		.st(st),
		.cmd(cmd)
	);

	kfpv_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.pos_value(s_tdata[47:0]),
		.vel_value(s_tdata[95:48]),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

endmodule

// File: tb/tb_kalman_filter_pos_vel.sv
// testbench: stream-level checks of the position/velocity kalman filter against a bit-exact predictor
`timescale 1ns / 100ps

module tb_kalman_filter_pos_vel;

	localparam logic [1:0] K_NOP = 2'd3;
	localparam longint VMAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint VMIN = -64'sh0000_8000_0000_0000;
	localparam longint RMAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint CYCLE_LIMIT = 20000000;
	localparam int N_RAND = 1080;

	typedef struct {
		logic [47:0] f [10];
		logic sing;
	} filt_out_t;

	typedef struct {
		logic [1:0] kind;
		longint pos;
		longint vel;
		bit typed;
		longint epos;
		longint evel;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [479:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_wr_en = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [46:0] cfg_data = '0;

	kalman_filter_pos_vel u_dut (.*);

	always #4 clk = ~clk;

	// filter model state
	longint dt_q, qp_q, qv_q, rp_q, rv_q;
	longint est_p, est_v;
	longint cv [4];

	filt_out_t expected_q [$];
	int errors = 0;
	longint cycles = 0;
	int n_kind [4] = '{0, 0, 0, 0};
	int n_sing = 0;
	int n_results = 0;
	stim_row_t tbl [$];

	function automatic longint clamp(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	function automatic longint signed_clamp(logic [127:0] m, bit neg);
		if (neg) return (m >= 128'h8000_0000_0000) ? VMIN : -longint'(m[63:0]);
		return (m > 128'h7FFF_FFFF_FFFF) ? VMAX : longint'(m[63:0]);
	endfunction

	function automatic longint q_mul(longint a, longint b);
		logic [127:0] ua, ub, m;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		m = (ua * ub + 128'h8000_0000) >> 32;
		return signed_clamp(m, (a < 0) != (b < 0));
	endfunction

	function automatic longint q_div(longint a, longint b);
		logic [127:0] ua, ub, q, r;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		q = (ua << 32) / ub;
		r = (ua << 32) % ub;
		if (2 * r >= ub) q = q + 1;
		return signed_clamp(q, (a < 0) != (b < 0));
	endfunction

	// K = P (P + R)^-1, returns 1 when det(S) is zero
	function automatic bit kalman_gain(input longint p [4], output longint k [4]);
		longint s00, s11, det, i00, i01, i10, i11;
		s00 = clamp(p[0] + rp_q);
		s11 = clamp(p[3] + rv_q);
		det = clamp(q_mul(s00, s11) - q_mul(p[1], p[2]));
		if (det == 0) begin
			k = '{0, 0, 0, 0};
			return 1'b1;
		end
		i00 = q_div(s11, det);
		i01 = q_div(clamp(-p[1]), det);
		i10 = q_div(clamp(-p[2]), det);
		i11 = q_div(s00, det);
		k[0] = clamp(q_mul(p[0], i00) + q_mul(p[1], i10));
		k[1] = clamp(q_mul(p[0], i01) + q_mul(p[1], i11));
		k[2] = clamp(q_mul(p[2], i00) + q_mul(p[3], i10));
		k[3] = clamp(q_mul(p[2], i01) + q_mul(p[3], i11));
		return 1'b0;
	endfunction

	function automatic filt_out_t filter_step(logic [1:0] kind, longint zp, longint zv);
		filt_out_t o;
		longint k [4];
		longint n [4];
		longint a00, a01, y0, y1;
		bit skipped;
		skipped = 1'b0;
		case (kind)
			kfpv_pkg::K_INIT: begin
				est_p = zp;
				est_v = zv;
			end
			kfpv_pkg::K_PRED: begin
				a00 = clamp(cv[0] + q_mul(dt_q, cv[2]));
				a01 = clamp(cv[1] + q_mul(dt_q, cv[3]));
				est_p = clamp(est_p + q_mul(dt_q, est_v));
				cv[0] = clamp(clamp(a00 + q_mul(dt_q, a01)) + qp_q);
				cv[1] = a01;
				cv[2] = clamp(cv[2] + q_mul(dt_q, cv[3]));
				cv[3] = clamp(cv[3] + qv_q);
			end
			kfpv_pkg::K_UPD: begin
				if (kalman_gain(cv, k)) begin
					skipped = 1'b1;
				end else begin
					y0 = clamp(zp - est_p);
					y1 = clamp(zv - est_v);
					est_p = clamp(est_p + clamp(q_mul(k[0], y0) + q_mul(k[1], y1)));
					est_v = clamp(est_v + clamp(q_mul(k[2], y0) + q_mul(k[3], y1)));
					n[0] = clamp(cv[0] - clamp(q_mul(k[0], cv[0]) + q_mul(k[1], cv[2])));
					n[1] = clamp(cv[1] - clamp(q_mul(k[0], cv[1]) + q_mul(k[1], cv[3])));
					n[2] = clamp(cv[2] - clamp(q_mul(k[2], cv[0]) + q_mul(k[3], cv[2])));
					n[3] = clamp(cv[3] - clamp(q_mul(k[2], cv[1]) + q_mul(k[3], cv[3])));
					cv = n;
				end
			end
			default: ;
		endcase
		void'(kalman_gain(cv, k));
		o.f[0] = est_p[47:0];
		o.f[1] = est_v[47:0];
		for (int i = 0; i < 4; i++) begin
			o.f[2 + i] = cv[i][47:0];
			o.f[6 + i] = k[i][47:0];
		end
		o.sing = skipped;
		return o;
	endfunction

	task automatic report(string what, logic [47:0] got, logic [47:0] want);
		errors++;
		$display("mismatch at result %0d: %s got %h want %h", n_results, what, got, want);
	endtask

	// result side: random stalls and field checks
	int stall_left = 0;
	always @(posedge clk) begin
		filt_out_t e;
		string names [10];
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			names = '{"position", "velocity", "cov_pp", "cov_pv", "cov_vp", "cov_vv",
				"gain_pp", "gain_pv", "gain_vp", "gain_vv"};
			if (expected_q.size() == 0) begin
				report("unexpected item", m_tdata[47:0], '0);
			end else begin
				e = expected_q.pop_front();
				for (int i = 0; i < 10; i++)
					if (m_tdata[48*i +: 48] !== e.f[i]) report(names[i], m_tdata[48*i +: 48], e.f[i]);
				if (m_tuser[0] !== e.sing)
					report("singular", 48'(m_tuser[0]), 48'(e.sing));
				if (m_tuser[0] === 1'b1) n_sing++;
			end
			n_results++;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			case ($urandom_range(0, 19))
				0: stall_left = $urandom_range(20, 400);
				1, 2, 3: stall_left = $urandom_range(1, 4);
				default: stall_left = 0;
			endcase
		end
	end

	task automatic send_item(logic [1:0] kind, longint zp, longint zv, bit typed = 0,
			longint epos = 0, longint evel = 0);
		int gap;
		filt_out_t o;
		// the block sees only the low 48 bits of each value
		zp = longint'(signed'(zp[47:0]));
		zv = longint'(signed'(zv[47:0]));
		case ($urandom_range(0, 9))
			0: gap = $urandom_range(30, 300);
			1, 2, 3: gap = $urandom_range(1, 5);
			default: gap = 0;
		endcase
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {zv[47:0], zp[47:0]};
		do @(posedge clk); while (!s_tready);
		o = filter_step(kind, zp, zv);
		if (typed) begin
			o.f[0] = epos[47:0];
			o.f[1] = evel[47:0];
		end
		expected_q.push_back(o);
		n_kind[kind]++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_regs(longint dt, longint qp, longint qv, longint rp, longint rv);
		longint v [5];
		v = '{dt, qp, qv, rp, rv};
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= v[i][46:0];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		dt_q = dt & RMAX;
		qp_q = qp & RMAX;
		qv_q = qv & RMAX;
		rp_q = rp & RMAX;
		rv_q = rv & RMAX;
	endtask

	function automatic longint rand_value();
		logic [47:0] r;
		r = 48'({$urandom(), $urandom()});
		case ($urandom_range(0, 11))
			0, 1: return longint'(signed'(r));
			2: return $urandom_range(0, 1) ? VMAX : VMIN;
			3: return 0;
			default: return longint'(signed'(r[37:0]));
		endcase
	endfunction

	function automatic longint rand_reg(int hi_bits);
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return longint'(r & ((64'd1 << hi_bits) - 1));
	endfunction

	initial begin
		int split;
		int k;
		dt_q = longint'(kfpv_pkg::DT_RST);
		qp_q = longint'(kfpv_pkg::QP_RST);
		qv_q = longint'(kfpv_pkg::QV_RST);
		rp_q = longint'(kfpv_pkg::RP_RST);
		rv_q = longint'(kfpv_pkg::RV_RST);
		est_p = 0;
		est_v = 0;
		cv = '{longint'(kfpv_pkg::COV_INIT), 0, 0, longint'(kfpv_pkg::COV_INIT)};

		// reset config rows, then zero config to drive covariance toward singular
		tbl = '{
			'{K_NOP, 0, 0, 1, 0, 0},
			'{kfpv_pkg::K_INIT, VMAX, VMIN, 1, VMAX, VMIN},
			'{kfpv_pkg::K_PRED, 0, 0, 0, 0, 0},
			'{kfpv_pkg::K_UPD, VMIN, VMAX, 0, 0, 0},
			'{kfpv_pkg::K_INIT, VMIN, VMAX, 1, VMIN, VMAX},
			'{K_NOP, 5, 5, 1, VMIN, VMAX},
			'{kfpv_pkg::K_INIT, 64'sh1_0000_0000, -64'sh2_0000_0000, 1,
				64'sh1_0000_0000, -64'sh2_0000_0000},
			'{kfpv_pkg::K_PRED, 0, 0, 0, 0, 0},
			'{kfpv_pkg::K_UPD, 64'sh1_8000_0000, -64'sh1_0000_0000, 0, 0, 0},
			'{kfpv_pkg::K_UPD, -1, 1, 0, 0, 0},
			'{kfpv_pkg::K_PRED, 0, 0, 0, 0, 0},
			'{kfpv_pkg::K_INIT, 0, 0, 1, 0, 0},
			'{kfpv_pkg::K_UPD, 64'sh1_0000_0000, 64'sh1_0000_0000, 0, 0, 0},
			'{kfpv_pkg::K_UPD, 64'sh2_0000_0000, 64'sh1_0000_0000, 0, 0, 0},
			'{kfpv_pkg::K_UPD, 0, 0, 0, 0, 0},
			'{kfpv_pkg::K_PRED, 0, 0, 0, 0, 0},
			'{K_NOP, 0, 0, 0, 0, 0},
			'{kfpv_pkg::K_UPD, VMAX, VMAX, 0, 0, 0}
		};
		split = 12;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (tbl[i]) begin
			if (i == split) begin
				wait_drained();
				set_regs(0, 0, 0, 0, 0);
			end
			send_item(tbl[i].kind, tbl[i].pos, tbl[i].vel, tbl[i].typed, tbl[i].epos,
				tbl[i].evel);
		end
		wait_drained();
		set_regs(longint'(kfpv_pkg::DT_RST), longint'(kfpv_pkg::QP_RST),
			longint'(kfpv_pkg::QV_RST), longint'(kfpv_pkg::RP_RST),
			longint'(kfpv_pkg::RV_RST));

		for (int n = 0; n < N_RAND; n++) begin
			if (n % 270 == 0 && n > 0) begin
				wait_drained();
				if (n == 540)
					set_regs(rand_reg(33), 0, rand_reg(30), 0, 0);
				else
					set_regs(rand_reg(34), rand_reg(28), rand_reg(32), rand_reg(30),
						rand_reg(34));
			end
			if (n == 135 || n == 700) begin
				@(posedge clk);
				s_tvalid <= 1'b0;
				while (expected_q.size() != 0) @(posedge clk);
			end
			k = $urandom_range(0, 19);
			if (k < 2) send_item(kfpv_pkg::K_INIT, rand_value(), rand_value());
			else if (k < 11) send_item(kfpv_pkg::K_PRED, rand_value(), rand_value());
			else if (k < 19) send_item(kfpv_pkg::K_UPD, est_p + rand_value() / 256,
				est_v + rand_value() / 256);
			else send_item(K_NOP, rand_value(), rand_value());
		end

		// all registers at their top value; covariance saturates and stays singular
		wait_drained();
		set_regs(RMAX, RMAX, RMAX, RMAX, RMAX);
		for (int n = 0; n < 20; n++)
			send_item(2'($urandom_range(0, 3)), rand_value(), rand_value());

		@(posedge clk);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("run: %0d results, kinds init/predict/update/unused %0d/%0d/%0d/%0d",
			n_results, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
		$display("run: %0d skipped updates, %0d register settings incl. zero and full scale",
			n_sing, 6);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
